// ===== design/vlrs_pkg.sv =====
// Shared types and codes of the variable-length record stack.
// No dependencies; used by the controller and the top level.
`default_nettype none

package vlrs_pkg;

	localparam int CMD_W  = 3;
	localparam int LEN_W  = 11;
	localparam int BYTE_W = 8;
	localparam int STAT_W = 2;

	localparam logic [CMD_W-1:0] CMD_PUSH  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PEEK  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_POP   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd3;
	localparam logic [CMD_W-1:0] CMD_ROOM  = 3'd4;

	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

	typedef struct packed {
		logic              load;
		logic [BYTE_W-1:0] data;
		logic              valid;
		logic [STAT_W-1:0] status;
		logic              empty;
		logic              eor;
	} res_t;

endpackage

`default_nettype wire

// ===== design/vlrs_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module vlrs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic                                  re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== design/vlrs_ctrl.sv =====
// Stack controller: top pointer, push tracking, header read/write sequencing
// and the read stage behind the RAM. Depends on vlrs_pkg and drives vlrs_ram.
`default_nettype none

module vlrs_ctrl #(
	parameter int STACK_BYTES  = 1024,
	parameter int HEADER_BYTES = 4,
	parameter int MAX_READ     = 64,
	localparam int AW = (STACK_BYTES > 1) ? $clog2(STACK_BYTES) : 1
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [vlrs_pkg::CMD_W-1:0]    cmd,
	input  wire logic [vlrs_pkg::BYTE_W-1:0]   data_byte,
	input  wire logic [vlrs_pkg::LEN_W-1:0]    length,
	input  wire logic                          last,
	input  wire logic                          slot_free,
	output vlrs_pkg::res_t                     res,
	output logic                               ram_we,
	output logic [AW-1:0]                      ram_waddr,
	output logic [vlrs_pkg::BYTE_W-1:0]        ram_wdata,
	output logic                               ram_re,
	output logic [AW-1:0]                      ram_raddr,
	input  wire logic [vlrs_pkg::BYTE_W-1:0]   ram_rdata
);

	localparam int LENW = vlrs_pkg::LEN_W;
	localparam int PTRW = $clog2(STACK_BYTES + 1);
	localparam int WAW  = (PTRW > LENW) ? PTRW : LENW;
	localparam int CW   = WAW + 2;
	localparam int RAW  = PTRW + 7;
	localparam int SW   = 8 * HEADER_BYTES;
	localparam int NW   = $clog2(MAX_READ + 1);
	localparam int MW   = (SW > NW) ? SW : NW;
	localparam int NTW  = ((SW > RAW) ? SW : RAW) + 2;
	localparam int HIW  = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;

	typedef enum logic [5:0] {
		ST_IDLE    = 6'b000001,
		ST_HDR_WR  = 6'b000010,
		ST_RD_HDR  = 6'b000100,
		ST_RD_CALC = 6'b001000,
		ST_RD_ZERO = 6'b010000,
		ST_RD_DATA = 6'b100000
	} state_t;

	state_t            state_q, state_d;
	logic [PTRW-1:0]   top_q, top_d;
	logic              push_active_q, push_active_d;
	logic              push_refused_q, push_refused_d;
	logic [WAW-1:0]    wa_q, wa_d;
	logic [LENW-1:0]   rec_len_q, rec_len_d;
	logic [HIW-1:0]    hdr_i_q, hdr_i_d;
	logic              remove_q, remove_d;
	logic [NW-1:0]     cap_q, cap_d;
	logic [SW-1:0]     stored_q, stored_nx;
	logic [NW-1:0]     n_q, n_d;
	logic [NW-1:0]     rd_i_q, rd_i_d;
	logic [RAW-1:0]    base_q, base_d;

	logic              rd_valid_s1, rd_valid_d;
	logic              rd_oob_s1;
	logic              rd_last_s1;
	logic [HIW-1:0]    rd_idx_s1;

	logic              accept;
	logic [CW-1:0]     len_ext, top_ext, hsum;
	logic              p_start, p_ref, p_wr, p_done;
	logic [LENW-1:0]   p_len;
	logic [WAW-1:0]    p_wa0, p_wa1;
	logic [PTRW-1:0]   p_hdr;
	logic              issue, data_move, rd_last_nx;
	logic [RAW-1:0]    rd_addr;
	logic [vlrs_pkg::BYTE_W-1:0] rd_byte;
	logic [31:0]       len_word;
	logic [NW-1:0]     calc_n;
	logic [NTW-1:0]    nt;

	assign in_ready = (state_q == ST_IDLE) && slot_free;
	assign accept   = in_valid && in_ready;
	assign len_ext  = CW'(length);
	assign top_ext  = CW'(top_q);
	assign hsum     = len_ext + CW'(HEADER_BYTES);
	assign rd_byte  = rd_oob_s1 ? '0 : ram_rdata;
	assign len_word = 32'(rec_len_q);

	// push bookkeeping for the current byte
	always_comb begin
		p_start = !push_active_q;
		p_len   = p_start ? length : rec_len_q;
		p_ref   = p_start ? (top_ext < hsum) : push_refused_q;
		if (p_start) begin
			p_wa0 = p_ref ? '0 : WAW'(top_ext - len_ext);
		end else begin
			p_wa0 = wa_q;
		end
		p_wr   = 1'b0;
		p_wa1  = p_wa0;
		p_done = last;
		if (p_ref) begin
			if (p_wa0 < WAW'(p_len)) begin
				p_wa1 = p_wa0 + WAW'(1);
			end
			p_done = last || (p_wa1 >= WAW'(p_len));
		end else begin
			p_wr = (p_wa0 < WAW'(top_q));
			if (p_wr) begin
				p_wa1 = p_wa0 + WAW'(1);
			end
			p_done = last || (p_wa1 >= WAW'(top_q));
		end
		p_hdr = PTRW'(top_ext - CW'(p_len) - CW'(HEADER_BYTES));
	end

	// merge the header byte sitting in the read stage
	always_comb begin
		stored_nx = stored_q;
		for (int b = 0; b < HEADER_BYTES; b++) begin
			if (rd_valid_s1 && (state_q == ST_RD_HDR || state_q == ST_RD_CALC) &&
			    rd_idx_s1 == HIW'(b)) begin
				stored_nx[8*b +: 8] = rd_byte;
			end
		end
		calc_n = (MW'(stored_nx) < MW'(cap_q)) ? NW'(stored_nx) : cap_q;
		nt     = NTW'(top_q) + NTW'(HEADER_BYTES) + NTW'(stored_nx);
	end

	assign data_move  = rd_valid_s1 && slot_free && (state_q == ST_RD_DATA);
	assign rd_last_nx = (rd_i_q == n_q - NW'(1));

	always_comb begin
		state_d        = state_q;
		top_d          = top_q;
		push_active_d  = push_active_q;
		push_refused_d = push_refused_q;
		wa_d           = wa_q;
		rec_len_d      = rec_len_q;
		hdr_i_d        = hdr_i_q;
		remove_d       = remove_q;
		cap_d          = cap_q;
		n_d            = n_q;
		rd_i_d         = rd_i_q;
		base_d         = base_q;
		issue          = 1'b0;
		rd_addr        = RAW'(top_q) + RAW'(hdr_i_q);
		ram_we         = 1'b0;
		ram_waddr      = p_wa0[AW-1:0];
		ram_wdata      = data_byte;
		res.load       = 1'b0;
		res.data       = '0;
		res.valid      = 1'b0;
		res.status     = vlrs_pkg::STAT_OK;
		res.eor        = 1'b1;

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (cmd)
						vlrs_pkg::CMD_PUSH: begin
							res.load       = 1'b1;
							res.status     = p_ref ? vlrs_pkg::STAT_FULL : vlrs_pkg::STAT_OK;
							ram_we         = !p_ref && p_wr;
							rec_len_d      = p_len;
							wa_d           = p_wa1;
							push_active_d  = !p_done;
							push_refused_d = p_ref && !p_done;
							if (p_done && !p_ref) begin
								top_d   = p_hdr;
								hdr_i_d = '0;
								state_d = ST_HDR_WR;
							end
						end
						vlrs_pkg::CMD_PEEK, vlrs_pkg::CMD_POP: begin
							push_active_d  = 1'b0;
							push_refused_d = 1'b0;
							if (top_q == PTRW'(STACK_BYTES)) begin
								res.load   = 1'b1;
								res.status = vlrs_pkg::STAT_EMPTY;
							end else begin
								remove_d = (cmd == vlrs_pkg::CMD_POP);
								cap_d    = (length > LENW'(MAX_READ)) ? NW'(MAX_READ)
								                                       : NW'(length);
								hdr_i_d  = '0;
								state_d  = ST_RD_HDR;
							end
						end
						vlrs_pkg::CMD_CLEAR: begin
							push_active_d  = 1'b0;
							push_refused_d = 1'b0;
							top_d          = PTRW'(STACK_BYTES);
							res.load       = 1'b1;
						end
						vlrs_pkg::CMD_ROOM: begin
							push_active_d  = 1'b0;
							push_refused_d = 1'b0;
							res.load       = 1'b1;
							res.status     = (top_ext > hsum) ? vlrs_pkg::STAT_OK
							                                  : vlrs_pkg::STAT_FULL;
						end
						default: begin
							res.load = 1'b1;
						end
					endcase
				end
			end
			ST_HDR_WR: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(top_q + PTRW'(hdr_i_q));
				ram_wdata = len_word[{hdr_i_q, 3'b000} +: 8];
				hdr_i_d   = hdr_i_q + HIW'(1);
				if (hdr_i_q == HIW'(HEADER_BYTES - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_RD_HDR: begin
				issue   = 1'b1;
				hdr_i_d = hdr_i_q + HIW'(1);
				if (hdr_i_q == HIW'(HEADER_BYTES - 1)) begin
					state_d = ST_RD_CALC;
				end
			end
			ST_RD_CALC: begin
				n_d    = calc_n;
				rd_i_d = '0;
				base_d = RAW'(top_q) + RAW'(HEADER_BYTES);
				if (remove_q) begin
					top_d = (nt > NTW'(STACK_BYTES)) ? PTRW'(STACK_BYTES) : PTRW'(nt);
				end
				state_d = (calc_n == '0) ? ST_RD_ZERO : ST_RD_DATA;
			end
			ST_RD_ZERO: begin
				if (slot_free) begin
					res.load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_RD_DATA: begin
				rd_addr = base_q + RAW'(rd_i_q);
				issue   = (rd_i_q < n_q) && (!rd_valid_s1 || data_move);
				if (issue) begin
					rd_i_d = rd_i_q + NW'(1);
				end
				if (data_move) begin
					res.load  = 1'b1;
					res.data  = rd_byte;
					res.valid = 1'b1;
					res.eor   = rd_last_s1;
					if (rd_last_s1) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		if (issue) begin
			rd_valid_d = 1'b1;
		end else if (state_q == ST_RD_DATA && !data_move) begin
			rd_valid_d = rd_valid_s1;
		end else begin
			rd_valid_d = 1'b0;
		end

		res.empty = (top_d == PTRW'(STACK_BYTES));
	end

	assign ram_re    = issue;
	assign ram_raddr = rd_addr[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			top_q          <= PTRW'(STACK_BYTES);
			push_active_q  <= 1'b0;
			push_refused_q <= 1'b0;
			wa_q           <= '0;
			rec_len_q      <= '0;
			hdr_i_q        <= '0;
			rd_i_q         <= '0;
			rd_valid_s1    <= 1'b0;
		end else begin
			state_q        <= state_d;
			top_q          <= top_d;
			push_active_q  <= push_active_d;
			push_refused_q <= push_refused_d;
			wa_q           <= wa_d;
			rec_len_q      <= rec_len_d;
			hdr_i_q        <= hdr_i_d;
			rd_i_q         <= rd_i_d;
			rd_valid_s1    <= rd_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		remove_q <= remove_d;
		cap_q    <= cap_d;
		n_q      <= n_d;
		base_q   <= base_d;
		if (accept) begin
			stored_q <= '0;
		end else begin
			stored_q <= stored_nx;
		end
		if (issue) begin
			rd_oob_s1  <= (rd_addr >= RAW'(STACK_BYTES));
			rd_idx_s1  <= hdr_i_q;
			rd_last_s1 <= (state_q == ST_RD_DATA) && rd_last_nx;
		end
	end

endmodule

`default_nettype wire

// ===== design/variable_length_record_stack_top.sv =====
// Top level of the variable-length record stack: stack RAM, controller and
// the result register. Depends on vlrs_pkg, vlrs_ram and vlrs_ctrl.
//
// Byte stack growing downward in one RAM of STACK_BYTES bytes; each record
// sits above a HEADER_BYTES little-endian length header. Push, clear, room
// check and unknown commands each give one result; the byte that closes an
// accepted push then starts the writes of the HEADER_BYTES header bytes
// through the single RAM write port. Peek and pop read the header bytes,
// size the run, pass through the registered RAM read, then give one byte per
// cycle from the RAM read port (n = min(stored length, capacity, MAX_READ)
// bytes, or one result for an empty stack or a zero-byte run), slowed only
// by out_ready.
// The stack RAM needs no clearing after reset.
`default_nettype none

module variable_length_record_stack_top #(
	parameter int STACK_BYTES  = 1024,
	parameter int HEADER_BYTES = 4,
	parameter int MAX_READ     = 64
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [vlrs_pkg::CMD_W-1:0]    cmd,
	input  wire logic [vlrs_pkg::BYTE_W-1:0]   data_byte,
	input  wire logic [vlrs_pkg::LEN_W-1:0]    length,
	input  wire logic                          last,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [vlrs_pkg::BYTE_W-1:0]        out_byte,
	output logic                               byte_valid,
	output logic [vlrs_pkg::STAT_W-1:0]        status,
	output logic                               is_empty,
	output logic                               end_of_run
);

	localparam int AW = (STACK_BYTES > 1) ? $clog2(STACK_BYTES) : 1;

	vlrs_pkg::res_t              res;
	logic                        slot_free;
	logic                        ram_we, ram_re;
	logic [AW-1:0]               ram_waddr, ram_raddr;
	logic [vlrs_pkg::BYTE_W-1:0] ram_wdata, ram_rdata;
	logic                        out_valid_q;

	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	vlrs_ram #(
		.WIDTH(vlrs_pkg::BYTE_W),
		.DEPTH(STACK_BYTES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	vlrs_ctrl #(
		.STACK_BYTES (STACK_BYTES),
		.HEADER_BYTES(HEADER_BYTES),
		.MAX_READ    (MAX_READ)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.data_byte(data_byte),
		.length   (length),
		.last     (last),
		.slot_free(slot_free),
		.res      (res),
		.ram_we   (ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.ram_re   (ram_re),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata)
	);

	// hold the result until its transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.load) begin
			out_byte   <= res.data;
			byte_valid <= res.valid;
			status     <= res.status;
			is_empty   <= res.empty;
			end_of_run <= res.eor;
		end
	end

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == vlrs_pkg::STAT_EMPTY |-> !byte_valid && end_of_run && is_empty)
		else $error("empty result with record byte or open run");

	a_byte_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && byte_valid |-> status == vlrs_pkg::STAT_OK)
		else $error("record byte with non-ok status");

	a_run_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !end_of_run |-> !in_ready)
		else $error("input taken in the middle of a run");

endmodule

`default_nettype wire

// ===== test/variable_length_record_stack_top_tb.sv =====
// Self-checking bench for variable_length_record_stack_top: random and directed
// push, peek, pop, clear and room-check traffic against an in-bench stack model.
// Depends on vlrs_pkg and the variable_length_record_stack_top RTL.
`timescale 1ns / 100ps

module variable_length_record_stack_top_tb;

	localparam int STACK_BYTES  = 1024;
	localparam int HEADER_BYTES = 4;
	localparam int MAX_READ     = 64;
	localparam int QUIET_LIMIT  = 2000;
	localparam int TAIL_CYCLES  = 80;

	localparam int CMD_W  = vlrs_pkg::CMD_W;
	localparam int BYTE_W = vlrs_pkg::BYTE_W;
	localparam int LEN_W  = vlrs_pkg::LEN_W;
	localparam int STAT_W = vlrs_pkg::STAT_W;

	localparam logic [CMD_W-1:0] CMD_UNDEF_LO = 3'd5;
	localparam logic [CMD_W-1:0] CMD_UNDEF_HI = 3'd7;

	typedef enum logic [1:0] {AIM_NONE, AIM_ROOM_EDGE, AIM_FIT_EDGE} aim_t;

	typedef struct packed {
		aim_t              aim;
		logic [CMD_W-1:0]  op;
		logic [BYTE_W-1:0] data;
		logic [LEN_W-1:0]  len;
		logic              last;
	} stack_cmd_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              valid;
		logic [STAT_W-1:0] status;
		logic              empty;
		logic              eor;
	} stack_reply_t;

	logic                clk        = 1'b0;
	logic                arst_n     = 1'b0;
	logic                in_valid   = 1'b0;
	logic                in_ready;
	logic [CMD_W-1:0]    cmd        = vlrs_pkg::CMD_PUSH;
	logic [BYTE_W-1:0]   data_byte  = '0;
	logic [LEN_W-1:0]    length     = '0;
	logic                last       = 1'b0;
	logic                out_valid;
	logic                out_ready  = 1'b0;
	logic [BYTE_W-1:0]   out_byte;
	logic                byte_valid;
	logic [STAT_W-1:0]   status;
	logic                is_empty;
	logic                end_of_run;

	stack_cmd_t   cmd_q[$];
	stack_reply_t reply_q[$];
	stack_cmd_t   cur_cmd;

	logic [BYTE_W-1:0] byte_mem [STACK_BYTES];
	bit                byte_known [STACK_BYTES];
	int                top_ptr;
	bit                push_open;
	bit                push_refused;
	int                wr_addr;
	int                rec_len;

	int queued_count   = 0;
	int accepted_count = 0;
	int err_count      = 0;
	int quiet_cycles   = 0;
	int send_idle_pct  = 15;
	int recv_stall_pct = 58;

	variable_length_record_stack_top #(
		.STACK_BYTES (STACK_BYTES),
		.HEADER_BYTES(HEADER_BYTES),
		.MAX_READ    (MAX_READ)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.data_byte (data_byte),
		.length    (length),
		.last      (last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.byte_valid(byte_valid),
		.status    (status),
		.is_empty  (is_empty),
		.end_of_run(end_of_run)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [BYTE_W-1:0] read_byte(input int addr);
		if (addr >= STACK_BYTES)
			return '0;
		return byte_mem[addr];
	endfunction

	function automatic void write_byte(input int addr, input logic [BYTE_W-1:0] v);
		if (addr >= 0 && addr < STACK_BYTES) begin
			byte_mem[addr]   = v;
			byte_known[addr] = 1'b1;
		end
	endfunction

	function automatic int stored_length();
		int stored;
		stored = 0;
		for (int i = 0; i < HEADER_BYTES; i++)
			stored |= int'(read_byte(top_ptr + i)) << (8 * i);
		return stored;
	endfunction

	function automatic void add_reply(input logic [BYTE_W-1:0] b, input logic v,
			input logic [STAT_W-1:0] st, input logic eor);
		stack_reply_t r;
		r.data   = b;
		r.valid  = v;
		r.status = st;
		r.empty  = (top_ptr == STACK_BYTES);
		r.eor    = eor;
		reply_q.push_back(r);
	endfunction

	// Advance the stack state by one transfer and queue the replies it causes.
	function automatic void stack_apply(input stack_cmd_t c);
		int                hdr, stored, cap, n, base;
		bit                done;
		logic [STAT_W-1:0] st;
		logic [BYTE_W-1:0] run [MAX_READ];
		if (c.op == vlrs_pkg::CMD_PUSH) begin
			if (!push_open) begin
				push_open    = 1'b1;
				rec_len      = int'(c.len);
				push_refused = top_ptr < rec_len + HEADER_BYTES;
				wr_addr      = push_refused ? 0 : top_ptr - rec_len;
			end
			if (push_refused) begin
				st = vlrs_pkg::STAT_FULL;
				if (wr_addr < rec_len)
					wr_addr++;
				done = c.last || wr_addr >= rec_len;
			end else begin
				st = vlrs_pkg::STAT_OK;
				if (wr_addr < top_ptr) begin
					write_byte(wr_addr, c.data);
					wr_addr++;
				end
				done = c.last || wr_addr >= top_ptr;
				if (done) begin
					hdr = top_ptr - rec_len - HEADER_BYTES;
					for (int i = 0; i < HEADER_BYTES; i++)
						write_byte(hdr + i, BYTE_W'(rec_len >> (8 * i)));
					top_ptr = hdr;
				end
			end
			if (done) begin
				push_open    = 1'b0;
				push_refused = 1'b0;
			end
			add_reply('0, 1'b0, st, 1'b1);
		end else if (c.op > vlrs_pkg::CMD_ROOM) begin
			add_reply('0, 1'b0, vlrs_pkg::STAT_OK, 1'b1);
		end else begin
			push_open    = 1'b0;
			push_refused = 1'b0;
			case (c.op)
				vlrs_pkg::CMD_PEEK, vlrs_pkg::CMD_POP: begin
					if (top_ptr == STACK_BYTES) begin
						add_reply('0, 1'b0, vlrs_pkg::STAT_EMPTY, 1'b1);
					end else begin
						stored = stored_length();
						cap    = (c.len > MAX_READ) ? MAX_READ : int'(c.len);
						n      = (stored < cap) ? stored : cap;
						base   = top_ptr + HEADER_BYTES;
						for (int i = 0; i < n; i++)
							run[i] = read_byte(base + i);
						if (c.op == vlrs_pkg::CMD_POP)
							top_ptr = (base + stored > STACK_BYTES) ? STACK_BYTES : base + stored;
						if (n == 0)
							add_reply('0, 1'b0, vlrs_pkg::STAT_OK, 1'b1);
						for (int i = 0; i < n; i++)
							add_reply(run[i], 1'b1, vlrs_pkg::STAT_OK, i == n - 1);
					end
				end
				vlrs_pkg::CMD_CLEAR: begin
					top_ptr = STACK_BYTES;
					add_reply('0, 1'b0, vlrs_pkg::STAT_OK, 1'b1);
				end
				default: begin
					add_reply('0, 1'b0,
						(top_ptr > c.len + HEADER_BYTES) ? vlrs_pkg::STAT_OK
						                                 : vlrs_pkg::STAT_FULL, 1'b1);
				end
			endcase
		end
	endfunction

	task automatic queue_cmd(input logic [CMD_W-1:0] op, input logic [BYTE_W-1:0] data,
			input int len, input bit lst, input aim_t aim = AIM_NONE);
		stack_cmd_t c;
		c.aim  = aim;
		c.op   = op;
		c.data = data;
		c.len  = len[LEN_W-1:0];
		c.last = lst;
		cmd_q.push_back(c);
		queued_count++;
	endtask

	// Queue nbytes push bytes; only the first carries the record length.
	task automatic queue_record(input int len, input int nbytes, input bit mark_last);
		for (int i = 0; i < nbytes; i++)
			queue_cmd(vlrs_pkg::CMD_PUSH, BYTE_W'($urandom_range(255)),
				(i == 0) ? len : int'($urandom_range(1024)),
				mark_last && (i == nbytes - 1));
	endtask

	task automatic queue_random(input int count);
		int target, pick, len;
		target = queued_count + count;
		while (queued_count < target) begin
			pick = $urandom_range(99);
			if (pick < 35) begin
				pick = $urandom_range(99);
				if (pick < 80) begin
					len = $urandom_range(12);
					queue_record(len, (len == 0) ? 1 : len, 1'($urandom_range(1)));
				end else if (pick < 92) begin
					len = $urandom_range(80, 13);
					queue_record(len, len, 1'($urandom_range(1)));
				end else if (pick < 96) begin
					queue_record(int'($urandom_range(1024, 100)), int'($urandom_range(3, 1)),
						1'b1);
				end else begin
					queue_cmd(vlrs_pkg::CMD_PUSH, BYTE_W'($urandom_range(255)), 0, 1'b1,
						AIM_FIT_EDGE);
				end
			end else if (pick < 75) begin
				queue_cmd((pick < 55) ? vlrs_pkg::CMD_PEEK : vlrs_pkg::CMD_POP,
					BYTE_W'($urandom_range(255)),
					($urandom_range(3) == 0) ? int'($urandom_range(1024))
					                         : int'($urandom_range(80)),
					1'($urandom_range(1)));
			end else if (pick < 83) begin
				queue_cmd(vlrs_pkg::CMD_ROOM, BYTE_W'($urandom_range(255)),
					int'($urandom_range(1024)), 1'($urandom_range(1)),
					($urandom_range(2) == 0) ? AIM_ROOM_EDGE : AIM_NONE);
			end else if (pick < 85) begin
				queue_cmd(vlrs_pkg::CMD_CLEAR, BYTE_W'($urandom_range(255)),
					int'($urandom_range(1024)), 1'($urandom_range(1)));
			end else if (pick < 88) begin
				queue_cmd(CMD_W'($urandom_range(CMD_UNDEF_HI, CMD_UNDEF_LO)),
					BYTE_W'($urandom_range(255)), int'($urandom_range(1024)),
					1'($urandom_range(1)));
			end else begin
				len = $urandom_range(16, 2);
				case ($urandom_range(2))
					0: begin
						queue_record(len, int'($urandom_range(len - 1, 1)), 1'b0);
						queue_cmd(CMD_W'($urandom_range(vlrs_pkg::CMD_ROOM, vlrs_pkg::CMD_PEEK)),
							BYTE_W'($urandom_range(255)), int'($urandom_range(80)),
							1'($urandom_range(1)));
					end
					1: begin
						len = $urandom_range(4);
						queue_record(len, len + int'($urandom_range(3, 1)),
							1'($urandom_range(1)));
					end
					default: begin
						queue_record(len, 1, 1'b0);
						queue_cmd(CMD_W'($urandom_range(CMD_UNDEF_HI, CMD_UNDEF_LO)),
							BYTE_W'($urandom_range(255)), int'($urandom_range(1024)),
							1'($urandom_range(1)));
						queue_record(int'($urandom_range(1024)), len - 1, 1'b1);
					end
				endcase
			end
		end
	endtask

	task automatic wait_drained();
		while (accepted_count != queued_count || reply_q.size() != 0)
			@(posedge clk);
	endtask

	// Driver: present one command at a time; shape it against the current stack state.
	always @(posedge clk or negedge arst_n) begin : feed_proc
		int stored, cap, n, k, base;
		if (!arst_n) begin
			in_valid     <= 1'b0;
			cmd          <= vlrs_pkg::CMD_PUSH;
			data_byte    <= '0;
			length       <= '0;
			last         <= 1'b0;
			top_ptr      = STACK_BYTES;
			push_open    = 1'b0;
			push_refused = 1'b0;
			wr_addr      = 0;
			rec_len      = 0;
			foreach (byte_known[i])
				byte_known[i] = 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				stack_apply(cur_cmd);
				accepted_count++;
			end
			if (!in_valid || in_ready) begin
				if (cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					cur_cmd = cmd_q.pop_front();
					if (cur_cmd.aim == AIM_ROOM_EDGE) begin
						k = top_ptr - HEADER_BYTES - 1 + int'($urandom_range(2));
						cur_cmd.len = (k < 0) ? '0 : k[LEN_W-1:0];
					end else if (cur_cmd.aim == AIM_FIT_EDGE && !push_open) begin
						k = top_ptr - HEADER_BYTES + int'($urandom_range(1));
						cur_cmd.len = (k < 0) ? '0 : k[LEN_W-1:0];
					end
					// Hold reads within bytes that have been written at least once.
					if ((cur_cmd.op == vlrs_pkg::CMD_PEEK || cur_cmd.op == vlrs_pkg::CMD_POP)
							&& top_ptr != STACK_BYTES) begin
						stored = stored_length();
						cap    = (cur_cmd.len > MAX_READ) ? MAX_READ : int'(cur_cmd.len);
						n      = (stored < cap) ? stored : cap;
						base   = top_ptr + HEADER_BYTES;
						k      = 0;
						while (k < n && (base + k >= STACK_BYTES || byte_known[base + k]))
							k++;
						if (k < n)
							cur_cmd.len = k[LEN_W-1:0];
					end
					cmd       <= cur_cmd.op;
					data_byte <= cur_cmd.data;
					length    <= cur_cmd.len;
					last      <= cur_cmd.last;
					in_valid  <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each result transfer with the oldest queued reply.
	always @(posedge clk or negedge arst_n) begin : check_proc
		stack_reply_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (reply_q.size() == 0) begin
					err_count++;
					$display("%0t: unexpected result byte=%02h valid=%0d status=%0d empty=%0d eor=%0d",
						$time, out_byte, byte_valid, status, is_empty, end_of_run);
				end else begin
					want = reply_q.pop_front();
					if (want.data !== out_byte || want.valid !== byte_valid
							|| want.status !== status || want.empty !== is_empty
							|| want.eor !== end_of_run) begin
						err_count++;
						$display({"%0t: mismatch expected byte=%02h valid=%0d status=%0d ",
							"empty=%0d eor=%0d, actual byte=%02h valid=%0d status=%0d ",
							"empty=%0d eor=%0d"}, $time, want.data, want.valid,
							want.status, want.empty, want.eor, out_byte, byte_valid,
							status, is_empty, end_of_run);
					end
				end
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		queue_cmd(vlrs_pkg::CMD_PEEK, 8'h00, MAX_READ, 1'b0);
		queue_cmd(vlrs_pkg::CMD_POP, 8'hff, 0, 1'b1);
		queue_cmd(vlrs_pkg::CMD_ROOM, 8'h00, STACK_BYTES - HEADER_BYTES - 1, 1'b0);
		queue_cmd(vlrs_pkg::CMD_ROOM, 8'h00, STACK_BYTES - HEADER_BYTES, 1'b0);
		queue_cmd(vlrs_pkg::CMD_PUSH, 8'hff, 0, 1'b0);
		queue_cmd(vlrs_pkg::CMD_PEEK, 8'h00, 5, 1'b0);
		queue_cmd(vlrs_pkg::CMD_PUSH, 8'h00, 3, 1'b0);
		queue_cmd(vlrs_pkg::CMD_PUSH, 8'ha5, 0, 1'b0);
		queue_cmd(vlrs_pkg::CMD_PUSH, 8'hff, 0, 1'b1);
		queue_cmd(vlrs_pkg::CMD_PEEK, 8'h00, STACK_BYTES, 1'b0);
		queue_cmd(vlrs_pkg::CMD_POP, 8'h00, 2, 1'b0);
		queue_cmd(vlrs_pkg::CMD_PUSH, 8'hb1, 2, 1'b0);
		queue_cmd(vlrs_pkg::CMD_PUSH, 8'hb2, 0, 1'b0);
		queue_cmd(vlrs_pkg::CMD_PUSH, 8'hb3, 1, 1'b0);
		queue_cmd(vlrs_pkg::CMD_PUSH, 8'h33, STACK_BYTES, 1'b0);
		queue_cmd(vlrs_pkg::CMD_PUSH, 8'hcc, 0, 1'b1);
		queue_cmd(vlrs_pkg::CMD_PUSH, 8'hab, 4, 1'b0);
		queue_cmd(CMD_UNDEF_HI, 8'hff, STACK_BYTES, 1'b1);
		queue_cmd(vlrs_pkg::CMD_PUSH, 8'hcd, 0, 1'b0);
		queue_cmd(vlrs_pkg::CMD_PEEK, 8'h00, MAX_READ, 1'b0);
		queue_cmd(vlrs_pkg::CMD_PUSH, 8'h11, 6, 1'b1);
		queue_cmd(vlrs_pkg::CMD_POP, 8'h00, MAX_READ, 1'b0);
		queue_cmd(vlrs_pkg::CMD_CLEAR, 8'h00, 0, 1'b0);
		queue_cmd(vlrs_pkg::CMD_POP, 8'h00, 7, 1'b0);
		queue_cmd(CMD_UNDEF_LO, 8'h00, 0, 1'b0);
		queue_random(150);

		wait_drained();
		send_idle_pct  = 58;
		recv_stall_pct = 15;
		queue_random(150);

		wait_drained();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		queue_random(150);

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_count == 0 && reply_q.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
